// ===== hdl/bgc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and codes of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

	localparam int unsigned KEY_W    = 8;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SEL_KEY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DC_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRACE     = 2'd2;

	localparam logic [KEY_W-1:0]   SEL_KEY_RST   = 8'd0;
	localparam logic [COUNT_W-1:0] DC_WINDOW_RST = 16'd300;
	localparam logic [COUNT_W-1:0] GRACE_RST     = 16'd2000;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_KEY  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		EV_SHORT_UP  = 2'd0,
		EV_LONG_DOWN = 2'd1,
		EV_LONG_UP   = 2'd2,
		EV_OTHER     = 2'd3
	} btn_evt_t;

	typedef enum logic [1:0] {
		ACT_SHORT      = 2'd0,
		ACT_DOUBLE     = 2'd1,
		ACT_LONG_START = 2'd2,
		ACT_LONG_END   = 2'd3
	} action_t;

	typedef struct packed {
		kind_t            kind;
		logic [KEY_W-1:0] btn_code;
		btn_evt_t         btn_evt;
	} item_t;

	typedef struct packed {
		logic    valid;
		action_t action;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0]   sel_key;
		logic [COUNT_W-1:0] dc_window;
		logic [COUNT_W-1:0] grace_period;
	} cfg_t;

endpackage

// ===== hdl/bgc_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_in_reg
// Input register: captures one word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module bgc_in_reg import bgc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t item_in,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic accept;

	// take a new word when empty or when the held one moves on this cycle
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ===== hdl/bgc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_core
// Gesture state and classification of one tick or key event per cycle in which advance is high.
// ----------------------------------------------------------------------------
module bgc_core import bgc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item_s1,
	input  cfg_t    cfg,
	output result_t res
);

	logic               short_pending_q, short_pending_d;
	logic               long_active_q, long_active_d;
	logic [COUNT_W-1:0] window_q, window_d;
	logic [COUNT_W-1:0] since_q, since_d;
	logic               in_grace;

	assign in_grace = since_q < cfg.grace_period;

	always_comb begin
		short_pending_d = short_pending_q;
		long_active_d   = long_active_q;
		window_d        = window_q;
		since_d         = since_q;
		res.valid       = 1'b0;
		res.action      = ACT_SHORT;
		if (item_s1.kind == KIND_TICK) begin
			if (in_grace) begin
				since_d = since_q + 1'b1;
			end
			if (short_pending_q) begin
				// window of zero expires like a window of one
				if (window_q <= COUNT_W'(1)) begin
					window_d        = '0;
					short_pending_d = 1'b0;
					res.valid       = 1'b1;
					res.action      = ACT_SHORT;
				end else begin
					window_d = window_q - 1'b1;
				end
			end
		end else if (!in_grace && item_s1.btn_code == cfg.sel_key) begin
			unique case (item_s1.btn_evt)
				EV_SHORT_UP: begin
					if (!long_active_q) begin
						if (short_pending_q) begin
							short_pending_d = 1'b0;
							window_d        = '0;
							res.valid       = 1'b1;
							res.action      = ACT_DOUBLE;
						end else begin
							short_pending_d = 1'b1;
							window_d        = cfg.dc_window;
						end
					end
				end
				EV_LONG_DOWN: begin
					long_active_d   = 1'b1;
					short_pending_d = 1'b0;
					window_d        = '0;
					res.valid       = 1'b1;
					res.action      = ACT_LONG_START;
				end
				EV_LONG_UP: begin
					if (long_active_q) begin
						long_active_d = 1'b0;
						res.valid     = 1'b1;
						res.action    = ACT_LONG_END;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_pending_q <= 1'b0;
			long_active_q   <= 1'b0;
			window_q        <= '0;
			since_q         <= '0;
		end else if (advance) begin
			short_pending_q <= short_pending_d;
			long_active_q   <= long_active_d;
			window_q        <= window_d;
			since_q         <= since_d;
		end
	end

endmodule

// ===== hdl/bgc_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_out_reg
// Result register: holds one action word until the sink takes it.
// ----------------------------------------------------------------------------
module bgc_out_reg import bgc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  result_t    res,
	output logic       free,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] action
);

	logic    out_valid_q;
	action_t action_q;

	// free when empty or draining this cycle
	assign free      = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign action    = action_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			action_q <= res.action;
		end
	end

endmodule

// ===== hdl/button_gesture_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_classifier_core
// Classifies tick and key-event words into click and long-press actions.
// ----------------------------------------------------------------------------
// Takes one word per cycle (a millisecond tick or a key event) and gives zero
// or one action word for it: short press, double click, long start, long end.
// Each word is held in the input register, is classified against the gesture
// state in one pass, and its action, if any, lands in the result register at
// the edge on which the word moves on, so an action word is offered once its
// input word has passed through both registers, and throughput is one word per
// clock while the sink keeps taking results. A stall on the result side backs up
// into the input once the input register holds a word. Key events are ignored
// until grace_period ticks have been seen since reset. Write the
// configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module button_gesture_classifier_core import bgc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [KEY_W-1:0]     btn_code,
	input  logic [1:0]           btn_evt,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           action
);

	cfg_t    cfg_q;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    free;
	logic    advance;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sel_key      <= SEL_KEY_RST;
			cfg_q.dc_window    <= DC_WINDOW_RST;
			cfg_q.grace_period <= GRACE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEL_KEY:   cfg_q.sel_key      <= cfg_data[KEY_W-1:0];
				REG_DC_WINDOW: cfg_q.dc_window    <= cfg_data[COUNT_W-1:0];
				REG_GRACE:     cfg_q.grace_period <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign item_in.kind     = kind_t'(kind);
	assign item_in.btn_code = btn_code;
	assign item_in.btn_evt  = btn_evt_t'(btn_evt);

	assign advance = valid_s1 && free;

	bgc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bgc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	bgc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.action    (action)
	);

endmodule
